### rtl/hv_pkg.sv
// shared types and constants for the host name validator
`default_nettype none

package hv_pkg;

    localparam int unsigned NAME_COUNT_W  = 8;
    localparam int unsigned LABEL_COUNT_W = 7;
    localparam int unsigned OCTET_W       = 10;
    localparam int unsigned DIGITS_W      = 3;
    localparam int unsigned LABELS_W      = 3;

    localparam int unsigned MAX_NAME_LEN  = 253;
    localparam int unsigned MAX_LABEL_LEN = 63;
    localparam int unsigned OCTET_MAX     = 255;
    localparam int unsigned QUAD_LABELS   = 4;
    localparam int unsigned QUAD_DIGITS   = 3;

    localparam logic [7:0] ASCII_DOT    = 8'h2E;
    localparam logic [7:0] ASCII_HYPHEN = 8'h2D;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_NINE   = 8'h39;
    localparam logic [7:0] ASCII_LC_A   = 8'h61;
    localparam logic [7:0] ASCII_LC_Z   = 8'h7A;
    localparam logic [7:0] ASCII_UC_A   = 8'h41;
    localparam logic [7:0] ASCII_UC_Z   = 8'h5A;

    typedef struct packed {
        logic       is_digit;
        logic       is_alpha;
        logic       is_dot;
        logic       is_hyph;
        logic [3:0] digit;
    } t_char_class;

endpackage

`default_nettype wire

### rtl/hv_char_if.sv
// character stream channel: one byte of the name and its end flag
`default_nettype none

interface hv_char_if;

    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       final_char;

    modport source (output valid, output character, output final_char, input ready);
    modport sink   (input valid, input character, input final_char, output ready);

endinterface

`default_nettype wire

### rtl/hv_verdict_if.sv
// verdict channel: one result word per name
`default_nettype none

interface hv_verdict_if;

    logic valid;
    logic ready;
    logic host_ok;

    modport source (output valid, output host_ok, input ready);
    modport sink   (input valid, input host_ok, output ready);

endinterface

`default_nettype wire

### rtl/hv_classify.sv
// character classifier: letter, digit, dot, hyphen and digit value
`default_nettype none

module hv_classify (
    input  wire logic [7:0]          i_character,
    output hv_pkg::t_char_class      o_class
);
    import hv_pkg::*;

    logic [7:0] w_offset;

    assign w_offset = i_character - ASCII_ZERO;

    always_comb begin
        o_class.is_digit = (i_character >= ASCII_ZERO) && (i_character <= ASCII_NINE);
        o_class.is_alpha = ((i_character >= ASCII_LC_A) && (i_character <= ASCII_LC_Z)) ||
                           ((i_character >= ASCII_UC_A) && (i_character <= ASCII_UC_Z));
        o_class.is_dot   = (i_character == ASCII_DOT);
        o_class.is_hyph  = (i_character == ASCII_HYPHEN);
        o_class.digit    = w_offset[3:0];
    end

endmodule

`default_nettype wire

### rtl/hv_track.sv
// per-name rule tracking state and end-of-name verdict
`default_nettype none

module hv_track (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire logic                i_final,
    input  wire hv_pkg::t_char_class i_class,
    output logic                     o_host_ok
);
    import hv_pkg::*;

    typedef struct packed {
        logic [NAME_COUNT_W-1:0]  name_count;
        logic [LABEL_COUNT_W-1:0] label_count;
        logic                     label_began_hyphen;
        logic                     prev_hyphen;
        logic                     syntax_bad;
        logic                     all_numeric;
        logic [OCTET_W-1:0]       octet_value;
        logic [DIGITS_W-1:0]      octet_digits;
        logic                     octet_lead_zero;
        logic                     quad_bad;
        logic [LABELS_W-1:0]      labels_seen;
    } t_hv_state;

    localparam t_hv_state C_RESET = '{
        name_count:         '0,
        label_count:        '0,
        label_began_hyphen: 1'b0,
        prev_hyphen:        1'b0,
        syntax_bad:         1'b0,
        all_numeric:        1'b1,
        octet_value:        '0,
        octet_digits:       '0,
        octet_lead_zero:    1'b0,
        quad_bad:           1'b0,
        labels_seen:        '0
    };

    function automatic t_hv_state close_label(input t_hv_state s);
        t_hv_state t;
        t = s;
        if ((s.label_count == '0) || s.prev_hyphen || s.label_began_hyphen) begin
            t.syntax_bad = 1'b1;
        end
        if (s.octet_value > OCTET_W'(OCTET_MAX)) begin
            t.quad_bad = 1'b1;
        end
        if (s.labels_seen != '1) begin
            t.labels_seen = s.labels_seen + LABELS_W'(1);
        end
        t.label_count        = '0;
        t.label_began_hyphen = 1'b0;
        t.prev_hyphen        = 1'b0;
        t.octet_value        = '0;
        t.octet_digits       = '0;
        t.octet_lead_zero    = 1'b0;
        return t;
    endfunction

    t_hv_state r_state;
    t_hv_state w_char;
    t_hv_state w_end;
    t_hv_state n_state;

    // state after this character
    always_comb begin
        w_char = r_state;
        if (r_state.name_count >= NAME_COUNT_W'(MAX_NAME_LEN)) begin
            w_char.syntax_bad = 1'b1;
        end
        if (r_state.name_count != '1) begin
            w_char.name_count = r_state.name_count + NAME_COUNT_W'(1);
        end
        if (!i_class.is_digit && !i_class.is_dot) begin
            w_char.all_numeric = 1'b0;
        end
        if (!(i_class.is_digit || i_class.is_alpha || i_class.is_dot || i_class.is_hyph)) begin
            w_char.syntax_bad = 1'b1;
        end
        if (i_class.is_dot) begin
            w_char = close_label(w_char);
        end else begin
            if (r_state.label_count >= LABEL_COUNT_W'(MAX_LABEL_LEN)) begin
                w_char.syntax_bad = 1'b1;
            end
            if (i_class.is_hyph && (r_state.label_count == '0)) begin
                w_char.label_began_hyphen = 1'b1;
            end
            if (r_state.label_count != '1) begin
                w_char.label_count = r_state.label_count + LABEL_COUNT_W'(1);
            end
            w_char.prev_hyphen = i_class.is_hyph;
            if (i_class.is_digit) begin
                if (r_state.octet_digits >= DIGITS_W'(QUAD_DIGITS)) begin
                    w_char.quad_bad = 1'b1;
                end
                if ((r_state.octet_digits != '0) && r_state.octet_lead_zero) begin
                    w_char.quad_bad = 1'b1;
                end
                if ((r_state.octet_digits == '0) && (i_class.digit == 4'd0)) begin
                    w_char.octet_lead_zero = 1'b1;
                end
                if (r_state.octet_digits < DIGITS_W'(QUAD_DIGITS)) begin
                    w_char.octet_value = (r_state.octet_value << 3) +
                                         (r_state.octet_value << 1) +
                                         OCTET_W'(i_class.digit);
                end
                if (r_state.octet_digits != '1) begin
                    w_char.octet_digits = r_state.octet_digits + DIGITS_W'(1);
                end
            end
        end
    end

    // last label closes at end of name
    always_comb begin
        w_end = close_label(w_char);
        o_host_ok = !w_end.syntax_bad &&
                    (!w_end.all_numeric ||
                     (!w_end.quad_bad && (w_end.labels_seen == LABELS_W'(QUAD_LABELS))));
    end

    always_comb begin
        n_state = r_state;
        if (i_step) begin
            n_state = i_final ? C_RESET : w_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_RESET;
        end else begin
            r_state <= n_state;
        end
    end

    property p_clear_after_name;
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_final) |=> (r_state == C_RESET);
    endproperty
    a_clear_after_name: assert property (p_clear_after_name)
        else $error("state not cleared after last word of name");

endmodule

`default_nettype wire

### rtl/hostname_validator.sv
// host name validator top level: input register, rule tracker, verdict register
//
//  channel     dir  words                        per name
//  i_char      in   character, final_char        one per character
//  o_verdict   out  host_ok                      one, after final_char
//
// one character per cycle, unless a final character waits on a stalled verdict; each character passes through
// the input register, and the verdict is registered when the final character leaves it.
// reset clears the input and output valid flags and the rule state.
// a stalled verdict holds only a final character; other characters keep flowing.
`default_nettype none

module hostname_validator (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    hv_char_if.sink       i_char,
    hv_verdict_if.source  o_verdict
);
    import hv_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_final;
    logic        r_out_valid;
    logic        r_host_ok;

    logic        w_out_free;
    logic        w_adv;
    logic        w_in_ready;
    logic        w_host_ok;
    t_char_class w_class;

    assign w_out_free = !r_out_valid || o_verdict.ready;
    assign w_adv      = r_in_valid && (!r_in_final || w_out_free);
    assign w_in_ready = !r_in_valid || w_adv;

    assign i_char.ready      = w_in_ready;
    assign o_verdict.valid   = r_out_valid;
    assign o_verdict.host_ok = r_host_ok;

    hv_classify u_classify (
        .i_character (r_in_char),
        .o_class     (w_class)
    );

    hv_track u_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_adv),
        .i_final   (r_in_final),
        .i_class   (w_class),
        .o_host_ok (w_host_ok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && w_in_ready) begin
            r_in_char  <= i_char.character;
            r_in_final <= i_char.final_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in_final) begin
            r_out_valid <= 1'b1;
        end else if (o_verdict.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_final) begin
            r_host_ok <= w_host_ok;
        end
    end

    property p_final_waits;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_final && !w_out_free) |=> r_in_valid;
    endproperty
    a_final_waits: assert property (p_final_waits)
        else $error("final word dropped while verdict stalled");

    property p_verdict_source;
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_adv && r_in_final);
    endproperty
    a_verdict_source: assert property (p_verdict_source)
        else $error("verdict raised without a final word");

    property p_no_overwrite;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_verdict.ready) |-> !(w_adv && r_in_final);
    endproperty
    a_no_overwrite: assert property (p_no_overwrite)
        else $error("verdict overwritten while stalled");

endmodule

`default_nettype wire

### tb/hv_name_checker.sv
`timescale 1ns / 1ps
// verdict checker: tracks the name rules per character and compares each verdict word
module hv_name_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    hv_char_if    i_char,
    hv_verdict_if i_verdict,
    output int    o_fail_count,
    output int    o_verdicts_pending
);

    import hv_pkg::*;

    typedef struct packed {
        logic [NAME_COUNT_W-1:0]  name_len;
        logic [LABEL_COUNT_W-1:0] label_len;
        logic                     label_hyph_start;
        logic                     last_hyph;
        logic                     rule_broken;
        logic                     digits_dots_only;
        logic [OCTET_W-1:0]       octet;
        logic [DIGITS_W-1:0]      octet_ndig;
        logic                     octet_zero_lead;
        logic                     quad_broken;
        logic [LABELS_W-1:0]      labels_done;
    } t_name_state;

    t_name_state st;
    logic        expected_ok[$];

    function automatic t_name_state clean_state();
        t_name_state s;
        s = '0;
        s.digits_dots_only = 1'b1;
        return s;
    endfunction

    task automatic end_label();
        if (st.label_len == 0 || st.last_hyph || st.label_hyph_start) begin
            st.rule_broken = 1'b1;
        end
        if (st.octet > OCTET_MAX) begin
            st.quad_broken = 1'b1;
        end
        if (st.labels_done != '1) begin
            st.labels_done++;
        end
        st.label_len        = '0;
        st.label_hyph_start = 1'b0;
        st.last_hyph        = 1'b0;
        st.octet            = '0;
        st.octet_ndig       = '0;
        st.octet_zero_lead  = 1'b0;
    endtask

    task automatic take_char(input logic [7:0] c, input logic last);
        logic is_digit;
        logic is_alpha;
        logic is_dot;
        logic is_hyph;
        logic ok;
        is_digit = c >= ASCII_ZERO && c <= ASCII_NINE;
        is_alpha = (c >= ASCII_LC_A && c <= ASCII_LC_Z) || (c >= ASCII_UC_A && c <= ASCII_UC_Z);
        is_dot   = c == ASCII_DOT;
        is_hyph  = c == ASCII_HYPHEN;

        if (st.name_len >= MAX_NAME_LEN) begin
            st.rule_broken = 1'b1;
        end
        if (st.name_len != '1) begin
            st.name_len++;
        end
        if (!is_digit && !is_dot) begin
            st.digits_dots_only = 1'b0;
        end
        if (!(is_digit || is_alpha || is_dot || is_hyph)) begin
            st.rule_broken = 1'b1;
        end

        if (is_dot) begin
            end_label();
        end else begin
            if (st.label_len >= MAX_LABEL_LEN) begin
                st.rule_broken = 1'b1;
            end
            if (is_hyph && st.label_len == 0) begin
                st.label_hyph_start = 1'b1;
            end
            if (st.label_len != '1) begin
                st.label_len++;
            end
            st.last_hyph = is_hyph;
            if (is_digit) begin
                if (st.octet_ndig >= QUAD_DIGITS) begin
                    st.quad_broken = 1'b1;
                end
                if (st.octet_ndig != 0 && st.octet_zero_lead) begin
                    st.quad_broken = 1'b1;
                end
                if (st.octet_ndig == 0 && c == ASCII_ZERO) begin
                    st.octet_zero_lead = 1'b1;
                end
                if (st.octet_ndig < QUAD_DIGITS) begin
                    st.octet = OCTET_W'(st.octet * 10 + (c - ASCII_ZERO));
                end
                if (st.octet_ndig != '1) begin
                    st.octet_ndig++;
                end
            end
        end

        if (last) begin
            end_label();
            ok = !st.rule_broken &&
                 (!st.digits_dots_only || (!st.quad_broken && st.labels_done == QUAD_LABELS));
            expected_ok = {expected_ok, ok};
            st = clean_state();
        end
    endtask

    always @(posedge i_clk) begin
        logic want;
        if (!i_rst_n) begin
            st = clean_state();
            expected_ok.delete();
            o_fail_count       = 0;
            o_verdicts_pending = 0;
        end else begin
            if (i_verdict.valid && i_verdict.ready) begin
                if (expected_ok.size() == 0) begin
                    $error("host_ok: unexpected word, expected none, actual %0b",
                           i_verdict.host_ok);
                    o_fail_count++;
                end else begin
                    want = expected_ok.pop_front();
                    if (i_verdict.host_ok !== want) begin
                        $error("host_ok mismatch: expected %0b, actual %0b",
                               want, i_verdict.host_ok);
                        o_fail_count++;
                    end
                end
            end
            if (i_char.valid && i_char.ready) begin
                take_char(i_char.character, i_char.final_char);
            end
            o_verdicts_pending = expected_ok.size();
        end
    end

endmodule

### tb/tb_hostname_validator.sv
`timescale 1ns / 1ps
// testbench top: clock, reset, host name stimulus, verdict back-pressure and final verdict
module tb_hostname_validator;

    import hv_pkg::*;

    localparam int NAME_CHARS   = 650;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 4;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    int         fail_count;
    int         verdicts_pending;
    int         idle_cycles = 0;
    int         chars_sent  = 0;
    int         ready_hold  = 0;
    logic       calm_name   = 1'b0;
    logic [7:0] name_chars[$];

    hv_char_if    char_ch();
    hv_verdict_if verdict_ch();

    hostname_validator dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_char    (char_ch),
        .o_verdict (verdict_ch)
    );

    hv_name_checker name_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_char             (char_ch),
        .i_verdict          (verdict_ch),
        .o_fail_count       (fail_count),
        .o_verdicts_pending (verdicts_pending)
    );

    always #5 i_clk = ~i_clk;

    // verdict back-pressure: long ready runs, short and occasional long stalls
    always @(negedge i_clk) begin
        int r;
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                verdict_ch.ready <= 1'b1;
                ready_hold       <= $urandom_range(20, 80);
            end else if (r < 65) begin
                verdict_ch.ready <= 1'b1;
                ready_hold       <= $urandom_range(0, 3);
            end else if (r < 92) begin
                verdict_ch.ready <= 1'b0;
                ready_hold       <= $urandom_range(0, 2);
            end else begin
                verdict_ch.ready <= 1'b0;
                ready_hold       <= $urandom_range(9, 29);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((char_ch.valid && char_ch.ready) || (verdict_ch.valid && verdict_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int sender_gap();
        int r;
        if (calm_name) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [7:0] label_char(input bit inner);
        int r;
        r = $urandom_range(0, inner ? 39 : 35);
        if (r < 20) begin
            return 8'(ASCII_LC_A + $urandom_range(0, 25));
        end
        if (r < 26) begin
            return 8'(ASCII_UC_A + $urandom_range(0, 25));
        end
        if (r < 36) begin
            return 8'(ASCII_ZERO + $urandom_range(0, 9));
        end
        return ASCII_HYPHEN;
    endfunction

    function automatic void add_char(input logic [7:0] c);
        name_chars = {name_chars, c};
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            add_char(s[i]);
        end
    endfunction

    task automatic send_name();
        int gap;
        foreach (name_chars[i]) begin
            gap = sender_gap();
            if (gap > 0) begin
                char_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            char_ch.valid      <= 1'b1;
            char_ch.character  <= name_chars[i];
            char_ch.final_char <= (i == name_chars.size() - 1);
            do @(posedge i_clk); while (!char_ch.ready);
            @(negedge i_clk);
            chars_sent++;
        end
        name_chars.delete();
    endtask

    initial begin
        string directed[$];
        int    pick;
        int    nlab;
        int    len;
        int    r;
        int    pos;

        directed = {"a", "255.0.1.99", ".a", "a-", "-b", "Z9.", "9"};
        char_ch.valid      = 1'b0;
        char_ch.character  = 8'h00;
        char_ch.final_char = 1'b0;
        verdict_ch.ready   = 1'b1;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_char(8'h00);
        send_name();
        add_char(8'hFF);
        send_name();
        foreach (directed[i]) begin
            push_text(directed[i]);
            send_name();
        end

        while (chars_sent < NAME_CHARS) begin
            calm_name = ($urandom_range(0, 3) == 0);
            pick      = $urandom_range(0, 99);
            if (pick < 35) begin
                nlab = $urandom_range(1, 4);
                for (int l = 0; l < nlab; l++) begin
                    if (l > 0) begin
                        add_char(ASCII_DOT);
                    end
                    len = $urandom_range(1, 10);
                    for (int k = 0; k < len; k++) begin
                        add_char(label_char(k > 0 && k < len - 1));
                    end
                end
            end else if (pick < 65) begin
                r    = $urandom_range(0, 9);
                nlab = (r == 0) ? 3 : (r == 1) ? 5 : QUAD_LABELS;
                for (int l = 0; l < nlab; l++) begin
                    if (l > 0) begin
                        add_char(ASCII_DOT);
                    end
                    r = $urandom_range(0, 19);
                    if (r < 3) begin
                        push_text($sformatf("%0d", $urandom_range(250, 259)));
                    end else if (r < 14) begin
                        push_text($sformatf("%0d", $urandom_range(0, 255)));
                    end else if (r < 16) begin
                        push_text($sformatf("%0d", $urandom_range(256, 999)));
                    end else if (r < 18) begin
                        push_text($sformatf("0%0d", $urandom_range(0, 99)));
                    end else if (r < 19) begin
                        push_text($sformatf("%0d", $urandom_range(1000, 99999)));
                    end
                    // otherwise the octet stays empty
                end
            end else if (pick < 78) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(120, 135)
                                                   : $urandom_range(61, 66);
                if ($urandom_range(0, 1) == 0) begin
                    push_text("ab.");
                end
                for (int k = 0; k < len; k++) begin
                    add_char(label_char(1'b0));
                end
                if ($urandom_range(0, 1) == 0) begin
                    push_text(".x");
                end
            end else if (pick < 81) begin
                len = $urandom_range(250, 258);
                for (int k = 0; k < len; k++) begin
                    add_char((k % 51 == 50) ? ASCII_DOT : label_char(1'b0));
                end
            end else begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    r = $urandom_range(0, 3);
                    unique case (r)
                        0: add_char(8'($urandom_range(0, 255)));
                        1: add_char(ASCII_DOT);
                        2: add_char(ASCII_HYPHEN);
                        default: add_char(label_char(1'b1));
                    endcase
                end
            end

            // damage a share of the well-formed names
            if (pick < 65 && $urandom_range(0, 6) == 0) begin
                pos = $urandom_range(0, name_chars.size() - 1);
                r   = $urandom_range(0, 2);
                name_chars[pos] = (r == 0) ? ASCII_DOT :
                                  (r == 1) ? ASCII_HYPHEN : 8'($urandom_range(0, 255));
            end
            send_name();
        end

        char_ch.valid <= 1'b0;
        while (verdicts_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
